// ===== design/dpad_pkg.sv =====
// dpad_pkg: shared types, register indexes and helpers for the DRAM address decoder
// used by dpad_decode and dram_physical_address_decoder; depends on nothing

package dpad_pkg;

  // default geometry limits
  localparam int ADDRESS_BITS = 46;
  localparam int MAX_ROW_BITS = 20;

  // field widths fixed by the decoded word format
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_IDX_BITS  = 3;
  localparam int ROW_IDX_BITS  = 20;
  localparam int COL_BITS      = 10;
  localparam int ROW_LSB       = 18;
  localparam int COL_LSB       = 6;
  localparam int HASH_BITS     = 14;
  localparam int ROW_WIDTH_BITS = 5;
  // floor log2 of rows per bank is log2(size) + this base, less the rank code
  localparam int ROW_WIDTH_BASE = 13;
  localparam int RANK_BIT_MIN  = 6;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DIMM_LAYOUT_CH0     = 3'd0,
    REG_DIMM_LAYOUT_CH1     = 3'd1,
    REG_RANK_INTERLEAVE_CH0 = 3'd2,
    REG_RANK_INTERLEAVE_CH1 = 3'd3,
    REG_CHANNEL_HASH_CTRL   = 3'd4
  } cfg_reg_e;

  // configuration registers as seen by the decode logic
  typedef struct packed {
    logic [CFG_DATA_BITS-1:0] dimm_layout_ch0;
    logic [CFG_DATA_BITS-1:0] dimm_layout_ch1;
    logic [CFG_DATA_BITS-1:0] rank_interleave_ch0;
    logic [CFG_DATA_BITS-1:0] rank_interleave_ch1;
    logic [CFG_DATA_BITS-1:0] channel_hash_control;
  } cfg_t;

  // one decoded word
  typedef struct packed {
    logic                    decode_valid;
    logic                    channel_index;
    logic                    rank_index;
    logic                    rank_known;
    logic                    rank_guessed;
    logic [1:0]              bank_group_index;
    logic [1:0]              bank_index;
    logic [COL_BITS-1:0]     column_index;
    logic [ROW_IDX_BITS-1:0] row_index;
    logic                    bank_row_known;
    logic                    bank_row_guessed;
  } result_t;

  // dimm size in GB for slot a (0) or b (1)
  function automatic logic [5:0] dimm_size(input logic [CFG_DATA_BITS-1:0] w,
                                           input logic slot);
    dimm_size = slot ? w[21:16] : w[5:0];
  endfunction

  // rank code (log2 of ranks) for slot a or b
  function automatic logic [1:0] rank_code(input logic [CFG_DATA_BITS-1:0] w,
                                           input logic slot);
    rank_code = slot ? w[13:12] : w[9:8];
  endfunction

  // floor log2 of a nonzero 6-bit size
  function automatic logic [2:0] size_log2(input logic [5:0] sz);
    logic [2:0] msb;
    msb = '0;
    for (int i = 0; i < 6; i++) begin
      if (sz[i]) msb = 3'(i);
    end
    size_log2 = msb;
  endfunction

endpackage

// ===== design/dpad_decode.sv =====
// dpad_decode: combinational address decode from registered address and config
// depends on dpad_pkg

module dpad_decode #(
  parameter int AddressBits = dpad_pkg::ADDRESS_BITS,
  parameter int MaxRowBits  = dpad_pkg::MAX_ROW_BITS
) (
  input  dpad_pkg::cfg_t           cfg_i,
  input  logic [AddressBits-1:0]   addr_i,
  output dpad_pkg::result_t        res_o
);

  logic [5:0]  size_c0a, size_c0b, size_c1a, size_c1b;
  logic        pop0, pop1;
  logic        hash_par;
  logic        ch;
  logic [dpad_pkg::CFG_DATA_BITS-1:0] ch_word, intra;
  logic        multi_rank;
  logic [4:0]  rbit;
  logic [31:0] addr_lo;
  logic [5:0]  first_size;
  logic [1:0]  first_rc;
  logic [dpad_pkg::ROW_WIDTH_BITS-1:0] rb;
  logic [dpad_pkg::ROW_IDX_BITS-1:0]   row_raw, row_keep;

  assign size_c0a = dpad_pkg::dimm_size(cfg_i.dimm_layout_ch0, 1'b0);
  assign size_c0b = dpad_pkg::dimm_size(cfg_i.dimm_layout_ch0, 1'b1);
  assign size_c1a = dpad_pkg::dimm_size(cfg_i.dimm_layout_ch1, 1'b0);
  assign size_c1b = dpad_pkg::dimm_size(cfg_i.dimm_layout_ch1, 1'b1);
  assign pop0 = (size_c0a != '0) || (size_c0b != '0);
  assign pop1 = (size_c1a != '0) || (size_c1b != '0);

  // parity of masked address bits 19:6
  assign hash_par = ^(addr_i[dpad_pkg::COL_LSB +: dpad_pkg::HASH_BITS] &
                      cfg_i.channel_hash_control[dpad_pkg::COL_LSB +: dpad_pkg::HASH_BITS]);

  // channel select: single populated channel wins, then hash, then bit 6
  always_comb begin
    priority if (pop0 && !pop1) begin
      ch = 1'b0;
    end else if (pop1 && !pop0) begin
      ch = 1'b1;
    end else if (cfg_i.channel_hash_control[0]) begin
      ch = hash_par;
    end else begin
      ch = addr_i[dpad_pkg::COL_LSB];
    end
  end

  // rank: multi-rank if any present dimm on the channel has a nonzero rank code
  assign ch_word = ch ? cfg_i.dimm_layout_ch1 : cfg_i.dimm_layout_ch0;
  assign intra   = ch ? cfg_i.rank_interleave_ch1 : cfg_i.rank_interleave_ch0;
  assign multi_rank =
    ((dpad_pkg::dimm_size(ch_word, 1'b0) != '0) &&
     (dpad_pkg::rank_code(ch_word, 1'b0) != '0)) ||
    ((dpad_pkg::dimm_size(ch_word, 1'b1) != '0) &&
     (dpad_pkg::rank_code(ch_word, 1'b1) != '0));
  assign rbit    = intra[4:0];
  assign addr_lo = addr_i[31:0];

  // geometry of the first present dimm, in slot order
  always_comb begin
    priority if (size_c0a != '0) begin
      first_size = size_c0a;
      first_rc   = dpad_pkg::rank_code(cfg_i.dimm_layout_ch0, 1'b0);
    end else if (size_c0b != '0) begin
      first_size = size_c0b;
      first_rc   = dpad_pkg::rank_code(cfg_i.dimm_layout_ch0, 1'b1);
    end else if (size_c1a != '0) begin
      first_size = size_c1a;
      first_rc   = dpad_pkg::rank_code(cfg_i.dimm_layout_ch1, 1'b0);
    end else begin
      first_size = size_c1b;
      first_rc   = dpad_pkg::rank_code(cfg_i.dimm_layout_ch1, 1'b1);
    end
  end

  // row bits per bank is floor log2 of size plus 13, less the rank code, whatever the device width
  assign rb = dpad_pkg::ROW_WIDTH_BITS'(dpad_pkg::size_log2(first_size)) +
              dpad_pkg::ROW_WIDTH_BITS'(dpad_pkg::ROW_WIDTH_BASE) -
              dpad_pkg::ROW_WIDTH_BITS'(first_rc);
  assign row_raw  = addr_i[dpad_pkg::ROW_LSB +: dpad_pkg::ROW_IDX_BITS];
  assign row_keep = ~({dpad_pkg::ROW_IDX_BITS{1'b1}} << rb);

  // assemble the word; everything is zero with no dimm present
  always_comb begin
    res_o = '0;
    if (pop0 || pop1) begin
      res_o.decode_valid  = 1'b1;
      res_o.channel_index = ch;
      if (!multi_rank) begin
        res_o.rank_known = 1'b1;
      end else if (intra[8] && (rbit >= 5'(dpad_pkg::RANK_BIT_MIN))) begin
        res_o.rank_known   = 1'b1;
        res_o.rank_guessed = 1'b1;
        res_o.rank_index   = addr_lo[rbit];
      end
      res_o.bank_group_index[0] = addr_i[7] ^ addr_i[14];
      res_o.bank_group_index[1] = addr_i[8] ^ addr_i[9] ^ addr_i[12] ^ addr_i[13] ^
                                  addr_i[18] ^ addr_i[19];
      res_o.bank_index[0] = addr_i[15] ^ addr_i[18];
      res_o.bank_index[1] = addr_i[16] ^ addr_i[19];
      res_o.column_index  = addr_i[dpad_pkg::COL_LSB +: dpad_pkg::COL_BITS];
      if ((rb != '0) && (rb <= dpad_pkg::ROW_WIDTH_BITS'(MaxRowBits))) begin
        res_o.row_index = row_raw & row_keep;
      end
      res_o.bank_row_known   = 1'b1;
      res_o.bank_row_guessed = 1'b1;
    end
  end

endmodule

// ===== design/dram_physical_address_decoder.sv =====
// dram_physical_address_decoder: top level, config registers and two-stage word pipeline
// depends on dpad_pkg and dpad_decode
//
//   channel | direction | handshake               | payload
//   in      | input     | in_valid_i / in_stall_o  | physical_address_i
//   out     | output    | out_valid_o / out_stall_i| decode_valid_o .. bank_row_guessed_o
//   cfg     | input     | cfg_wr_en_i              | cfg_idx_i, cfg_wdata_i
//
// one word per cycle while the output is not stalled; address register then result register
// with the decode logic between them
// reset clears the config registers and both stage valids; no clearing pass
// the input is stalled only when both stages hold a word and the output is stalled

module dram_physical_address_decoder #(
  parameter int AddressBits = dpad_pkg::ADDRESS_BITS,
  parameter int MaxRowBits  = dpad_pkg::MAX_ROW_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration write port
  input  logic                                cfg_wr_en_i,
  input  logic [dpad_pkg::CFG_IDX_BITS-1:0]   cfg_idx_i,
  input  logic [dpad_pkg::CFG_DATA_BITS-1:0]  cfg_wdata_i,
  // address channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [AddressBits-1:0]              physical_address_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                decode_valid_o,
  output logic                                channel_index_o,
  output logic                                rank_index_o,
  output logic                                rank_known_o,
  output logic                                rank_guessed_o,
  output logic [1:0]                          bank_group_index_o,
  output logic [1:0]                          bank_index_o,
  output logic [dpad_pkg::COL_BITS-1:0]       column_index_o,
  output logic [dpad_pkg::ROW_IDX_BITS-1:0]   row_index_o,
  output logic                                bank_row_known_o,
  output logic                                bank_row_guessed_o
);

  dpad_pkg::cfg_t      cfg_q;
  logic                s1_valid_q;
  logic [AddressBits-1:0] s1_addr_q;
  logic                out_valid_q;
  dpad_pkg::result_t   res_d, res_q;
  logic                s1_adv;
  logic                in_take;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_wr_en_i) begin
      unique case (dpad_pkg::cfg_reg_e'(cfg_idx_i))
        dpad_pkg::REG_DIMM_LAYOUT_CH0:     cfg_q.dimm_layout_ch0      <= cfg_wdata_i;
        dpad_pkg::REG_DIMM_LAYOUT_CH1:     cfg_q.dimm_layout_ch1      <= cfg_wdata_i;
        dpad_pkg::REG_RANK_INTERLEAVE_CH0: cfg_q.rank_interleave_ch0  <= cfg_wdata_i;
        dpad_pkg::REG_RANK_INTERLEAVE_CH1: cfg_q.rank_interleave_ch1  <= cfg_wdata_i;
        dpad_pkg::REG_CHANNEL_HASH_CTRL:   cfg_q.channel_hash_control <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // pipeline flow control
  assign s1_adv     = !out_valid_q || !out_stall_i;
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign in_take    = in_valid_i && !in_stall_o;

  // address stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_take) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_addr_q <= physical_address_i;
    end
  end

  // decode logic
  dpad_decode #(
    .AddressBits (AddressBits),
    .MaxRowBits  (MaxRowBits)
  ) u_decode (
    .cfg_i  (cfg_q),
    .addr_i (s1_addr_q),
    .res_o  (res_d)
  );

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_valid_q) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign decode_valid_o     = res_q.decode_valid;
  assign channel_index_o    = res_q.channel_index;
  assign rank_index_o       = res_q.rank_index;
  assign rank_known_o       = res_q.rank_known;
  assign rank_guessed_o     = res_q.rank_guessed;
  assign bank_group_index_o = res_q.bank_group_index;
  assign bank_index_o       = res_q.bank_index;
  assign column_index_o     = res_q.column_index;
  assign row_index_o        = res_q.row_index;
  assign bank_row_known_o   = res_q.bank_row_known;
  assign bank_row_guessed_o = res_q.bank_row_guessed;

  // input held back only with both stages full
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && out_valid_q))
    else $error("input stalled with a free stage");

  // an empty decode gives an all-zero word
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !decode_valid_o) |-> (res_q == '0))
    else $error("nonzero word without a dimm present");

  // an interleave rank is always a known rank
  a_rank_flags: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rank_guessed_o) |-> rank_known_o)
    else $error("guessed rank not marked known");

  // rank index only comes from the interleave bit
  a_rank_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && rank_index_o) |-> rank_guessed_o)
    else $error("rank index set without interleave");

endmodule
